@@ hdl/isa_pkg.sv @@
`timescale 1ns / 1ps
// Package for the indexed shift array: item types, codes and the control store.
// Used by indexed_shift_array_top; depends on nothing else.
package isa_pkg;

  // Table geometry
  localparam int unsigned DEPTH  = 16;
  localparam int unsigned AW     = $clog2(DEPTH);
  localparam int unsigned CW     = $clog2(DEPTH + 1);
  localparam int unsigned UPC_W  = 4;

  // Field widths fixed by the item format
  localparam int unsigned OP_W   = 2;
  localparam int unsigned IDX_W  = 4;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned ST_W   = 2;
  localparam int unsigned CNT_W  = 5;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_PLACE  = 2'd2,
    OP_READ   = 2'd3
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [OP_W-1:0]          operation;
    logic [IDX_W-1:0]         index;
    logic signed [WORD_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [ST_W-1:0]          status;
    logic signed [WORD_W-1:0] read_data;
    logic [CNT_W-1:0]         count;
  } out_item_t;

  // Control word fields
  typedef enum logic [1:0] {RD_NONE, RD_PTR_M1, RD_PTR_P1, RD_IDX} rd_sel_e;
  typedef enum logic [1:0] {WR_NONE, WR_PTR_RD, WR_IDX_VAL} wr_sel_e;
  typedef enum logic [1:0] {PTR_HOLD, PTR_LOAD, PTR_DEC, PTR_INC} ptr_op_e;
  typedef enum logic [1:0] {CNT_HOLD, CNT_INC, CNT_DEC} cnt_op_e;
  typedef enum logic [1:0] {EM_NONE, EM_PLAIN, EM_READ} emit_e;
  typedef enum logic [2:0] {
    CD_ALWAYS,    // jump to target
    CD_PTR_EQ,    // jump when pointer reached the index, else fall through
    CD_PTR_LAST,  // jump when pointer+1 reaches the count, else fall through
    CD_OUT_BUSY,  // hold while the result waits to be taken, else back to idle
    CD_DISPATCH   // idle: new item to its routine, rejected item to result step
  } cond_e;

  typedef struct packed {
    rd_sel_e          rd_sel;
    wr_sel_e          wr_sel;
    ptr_op_e          ptr_op;
    cnt_op_e          cnt_op;
    emit_e            emit;
    cond_e            cond;
    logic [UPC_W-1:0] target;
  } ucw_t;

  // Program addresses
  localparam logic [UPC_W-1:0] UPC_IDLE     = 4'd0;
  localparam logic [UPC_W-1:0] UPC_INS_TEST = 4'd1;
  localparam logic [UPC_W-1:0] UPC_INS_MOVE = 4'd2;
  localparam logic [UPC_W-1:0] UPC_INS_PUT  = 4'd3;
  localparam logic [UPC_W-1:0] UPC_REM_TEST = 4'd4;
  localparam logic [UPC_W-1:0] UPC_REM_MOVE = 4'd5;
  localparam logic [UPC_W-1:0] UPC_REM_DROP = 4'd6;
  localparam logic [UPC_W-1:0] UPC_PLC_PUT  = 4'd7;
  localparam logic [UPC_W-1:0] UPC_RD_FETCH = 4'd8;
  localparam logic [UPC_W-1:0] UPC_RD_EMIT  = 4'd9;
  localparam logic [UPC_W-1:0] UPC_EMIT     = 4'd10;

  // Control store: one word per program step
  function automatic ucw_t ucode(input logic [UPC_W-1:0] upc);
    ucw_t w;
    w = '{RD_NONE, WR_NONE, PTR_HOLD, CNT_HOLD, EM_NONE, CD_ALWAYS, UPC_IDLE};
    unique case (upc)
      UPC_IDLE:     w = '{RD_NONE, WR_NONE, PTR_LOAD, CNT_HOLD, EM_NONE,
                          CD_DISPATCH, UPC_IDLE};
      // insert: walk down from the count, moving each entry up one
      UPC_INS_TEST: w = '{RD_PTR_M1, WR_NONE, PTR_HOLD, CNT_HOLD, EM_NONE,
                          CD_PTR_EQ, UPC_INS_PUT};
      UPC_INS_MOVE: w = '{RD_NONE, WR_PTR_RD, PTR_DEC, CNT_HOLD, EM_NONE,
                          CD_ALWAYS, UPC_INS_TEST};
      UPC_INS_PUT:  w = '{RD_NONE, WR_IDX_VAL, PTR_HOLD, CNT_INC, EM_NONE,
                          CD_ALWAYS, UPC_EMIT};
      // remove: walk up from the index, moving each entry down one
      UPC_REM_TEST: w = '{RD_PTR_P1, WR_NONE, PTR_HOLD, CNT_HOLD, EM_NONE,
                          CD_PTR_LAST, UPC_REM_DROP};
      UPC_REM_MOVE: w = '{RD_NONE, WR_PTR_RD, PTR_INC, CNT_HOLD, EM_NONE,
                          CD_ALWAYS, UPC_REM_TEST};
      UPC_REM_DROP: w = '{RD_NONE, WR_NONE, PTR_HOLD, CNT_DEC, EM_NONE,
                          CD_ALWAYS, UPC_EMIT};
      UPC_PLC_PUT:  w = '{RD_NONE, WR_IDX_VAL, PTR_HOLD, CNT_INC, EM_NONE,
                          CD_ALWAYS, UPC_EMIT};
      UPC_RD_FETCH: w = '{RD_IDX, WR_NONE, PTR_HOLD, CNT_HOLD, EM_NONE,
                          CD_ALWAYS, UPC_RD_EMIT};
      UPC_RD_EMIT:  w = '{RD_NONE, WR_NONE, PTR_HOLD, CNT_HOLD, EM_READ,
                          CD_OUT_BUSY, UPC_RD_EMIT};
      UPC_EMIT:     w = '{RD_NONE, WR_NONE, PTR_HOLD, CNT_HOLD, EM_PLAIN,
                          CD_OUT_BUSY, UPC_EMIT};
      default:      w = '{RD_NONE, WR_NONE, PTR_HOLD, CNT_HOLD, EM_NONE,
                          CD_ALWAYS, UPC_IDLE};
    endcase
    return w;
  endfunction

  // Entry point of each routine, or the plain result step on a rejected item
  function automatic logic [UPC_W-1:0] dispatch(input op_e op, input status_e st);
    logic [UPC_W-1:0] t;
    t = UPC_EMIT;
    if (st == ST_DONE) begin
      unique case (op)
        OP_INSERT: t = UPC_INS_TEST;
        OP_REMOVE: t = UPC_REM_TEST;
        OP_PLACE:  t = UPC_PLC_PUT;
        OP_READ:   t = UPC_RD_FETCH;
        default:   t = UPC_EMIT;
      endcase
    end
    return t;
  endfunction

endpackage

@@ hdl/indexed_shift_array_top.sv @@
`timescale 1ns / 1ps
// Indexed shift array: microcoded sequencer over a single-port entry memory.
// Steps: one memory access per step; each moved entry takes a read and a write step.
// Throughput: one item at a time; the next item is taken once the result is in
//   the output register, even while that result still waits to be taken.
// Reset: asynchronous, clears count, sequencer and output valid; entries undefined.
// Depends on isa_pkg.
module indexed_shift_array_top
  import isa_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  // Entry memory and datapath registers
  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_q;
  logic [UPC_W-1:0]  upc_q, upc_d;
  logic [AW-1:0]     ptr_q, ptr_d;
  logic [CW-1:0]     count_q, count_d;
  op_e               op_q;
  logic [IDX_W-1:0]  idx_q;
  logic [WORD_W-1:0] val_q;
  status_e           status_q, status_in;
  logic              out_valid_q;
  out_item_t         out_q;

  ucw_t              uw;
  logic              in_acc;
  logic              out_busy;
  logic              ptr_eq;
  logic              ptr_last;
  logic [AW-1:0]     rd_addr;
  logic              rd_en;
  logic [AW-1:0]     wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic              wr_en;
  logic              emit_go;
  op_e               op_in;

  assign uw       = ucode(upc_q);
  assign in_stall_o = (upc_q != UPC_IDLE);
  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_busy = out_valid_q && out_stall_i;
  assign op_in    = op_e'(in_item_i.operation);

  // Checks on an arriving item against the live count
  always_comb begin
    status_in = ST_DONE;
    unique case (op_in)
      OP_INSERT: begin
        if ({1'b0, in_item_i.index} >= CW'(count_q)) status_in = ST_RANGE;
        else if (count_q >= CW'(DEPTH))               status_in = ST_FULL;
      end
      OP_PLACE: begin
        if (count_q >= CW'(DEPTH))                       status_in = ST_FULL;
        else if ({1'b0, in_item_i.index} >= CW'(DEPTH)) status_in = ST_RANGE;
      end
      default: begin
        if ({1'b0, in_item_i.index} >= CW'(count_q)) status_in = ST_RANGE;
      end
    endcase
  end

  // Loop conditions
  assign ptr_eq   = (ptr_q == AW'(idx_q));
  assign ptr_last = ((CW'(ptr_q) + CW'(1)) >= count_q);

  // Memory address and data selection
  always_comb begin
    rd_en   = 1'b1;
    rd_addr = ptr_q;
    case (uw.rd_sel)
      RD_PTR_M1: rd_addr = ptr_q - AW'(1);
      RD_PTR_P1: rd_addr = ptr_q + AW'(1);
      RD_IDX:    rd_addr = AW'(idx_q);
      default:   rd_en   = 1'b0;
    endcase
  end

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = ptr_q;
    wr_data = rd_q;
    case (uw.wr_sel)
      WR_PTR_RD:  wr_addr = ptr_q;
      WR_IDX_VAL: begin
        wr_addr = AW'(idx_q);
        wr_data = val_q;
      end
      default:    wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // Sequencer: next step, pointer and count
  assign emit_go = (uw.emit != EM_NONE) && !out_busy;

  always_comb begin
    upc_d = upc_q + UPC_W'(1);
    case (uw.cond)
      CD_ALWAYS:   upc_d = uw.target;
      CD_PTR_EQ:   if (ptr_eq)   upc_d = uw.target;
      CD_PTR_LAST: if (ptr_last) upc_d = uw.target;
      CD_OUT_BUSY: upc_d = out_busy ? uw.target : UPC_IDLE;
      CD_DISPATCH: upc_d = in_acc ? dispatch(op_in, status_in) : upc_q;
      default:     upc_d = UPC_IDLE;
    endcase
  end

  always_comb begin
    ptr_d = ptr_q;
    case (uw.ptr_op)
      PTR_LOAD: ptr_d = (op_in == OP_INSERT) ? AW'(count_q) : AW'(in_item_i.index);
      PTR_DEC:  ptr_d = ptr_q - AW'(1);
      PTR_INC:  ptr_d = ptr_q + AW'(1);
      default:  ptr_d = ptr_q;
    endcase
  end

  always_comb begin
    count_d = count_q;
    case (uw.cnt_op)
      CNT_INC: count_d = count_q + CW'(1);
      CNT_DEC: count_d = count_q - CW'(1);
      default: count_d = count_q;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q       <= UPC_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      upc_q   <= upc_d;
      count_q <= count_d;
      if (emit_go) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Item and result payload
  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    if (in_acc) begin
      op_q     <= op_in;
      idx_q    <= in_item_i.index;
      val_q    <= in_item_i.value;
      status_q <= status_in;
    end
    if (emit_go) begin
      out_q.status    <= status_q;
      out_q.read_data <= (uw.emit == EM_READ) ? rd_q : '0;
      out_q.count     <= CNT_W'(count_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Assertions
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count above capacity");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == $past(count_q)) || (count_q == $past(count_q) + CW'(1)) ||
    (count_q == $past(count_q) - CW'(1)))
    else $error("entry count moved by more than one");

  a_leave_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (upc_q != UPC_IDLE))
    else $error("accepted item not dispatched");

  a_ins_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upc_q == UPC_INS_TEST) |-> ({1'b0, ptr_q} >= {1'b0, AW'(idx_q)}))
    else $error("insert walk passed its index");

  a_count_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_go && (op_q == OP_READ)) |-> (count_d == count_q))
    else $error("read changed the count");

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for indexed_shift_array_top: directed and random table
// operations against a local prediction of the table. Depends on isa_pkg.
module tb;
  import isa_pkg::*;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;

  // Predicted table contents, which entries hold a written word, live count
  logic signed [WORD_W-1:0] tbl_words [DEPTH];
  bit                       tbl_known [DEPTH];
  int unsigned              tbl_count;

  out_item_t table_replies_q [$];
  out_item_t reply_due;
  int        mismatches = 0;
  int        takes = 0;
  int        takes_seen = 0;
  int        hold_cycles = 0;
  bit        in_quiet;
  bit        out_quiet;
  bit        filling;

  indexed_shift_array_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Apply one operation to the predicted table and give the reply it yields
  function automatic out_item_t table_op_outcome(input in_item_t it);
    out_item_t   r;
    int unsigned idx;
    int          i;
    r.status    = ST_DONE;
    r.read_data = '0;
    idx         = {28'd0, it.index};
    case (op_e'(it.operation))
      OP_INSERT: begin
        if (idx >= tbl_count) begin
          r.status = ST_RANGE;
        end else if (tbl_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (i = tbl_count; i > idx; i--) begin
            tbl_words[i] = tbl_words[i-1];
            tbl_known[i] = tbl_known[i-1];
          end
          tbl_words[idx] = it.value;
          tbl_known[idx] = 1'b1;
          tbl_count++;
        end
      end
      OP_REMOVE: begin
        if (idx >= tbl_count) begin
          r.status = ST_RANGE;
        end else begin
          for (i = idx; i + 1 < tbl_count; i++) begin
            tbl_words[i] = tbl_words[i+1];
            tbl_known[i] = tbl_known[i+1];
          end
          tbl_count--;
        end
      end
      OP_PLACE: begin
        if (tbl_count >= DEPTH) begin
          r.status = ST_FULL;
        end else if (idx >= DEPTH) begin
          r.status = ST_RANGE;
        end else begin
          tbl_words[idx] = it.value;
          tbl_known[idx] = 1'b1;
          tbl_count++;
        end
      end
      default: begin
        if (idx >= tbl_count) r.status = ST_RANGE;
        else r.read_data = tbl_words[idx];
      end
    endcase
    r.count = tbl_count[CNT_W-1:0];
    return r;
  endfunction

  function automatic in_item_t table_op(input op_e op, input int unsigned idx,
                                        input logic [WORD_W-1:0] val);
    in_item_t it;
    it.operation = op;
    it.index     = idx[IDX_W-1:0];
    it.value     = val;
    return it;
  endfunction

  // Random operation, steered towards filling or draining the table
  function automatic in_item_t pick_table_op();
    op_e         op;
    int unsigned idx;
    int unsigned roll;
    int unsigned k;
    int unsigned j;
    bit          found;
    roll = $urandom_range(0, 99);
    if (filling) begin
      op = (roll < 35) ? OP_INSERT : (roll < 55) ? OP_PLACE :
           (roll < 80) ? OP_READ : OP_REMOVE;
    end else begin
      op = (roll < 40) ? OP_REMOVE : (roll < 65) ? OP_READ :
           (roll < 85) ? OP_INSERT : OP_PLACE;
    end
    if (tbl_count == 0 || $urandom_range(0, 99) < 15) begin
      idx = $urandom_range(0, DEPTH - 1);
    end else if (op == OP_PLACE) begin
      idx = $urandom_range(0, (tbl_count < DEPTH) ? tbl_count : DEPTH - 1);
    end else begin
      idx = $urandom_range(0, tbl_count - 1);
    end
    // never read a live entry that holds no written word
    if (op == OP_READ && idx < tbl_count && !tbl_known[idx]) begin
      found = 1'b0;
      for (j = 0; j < tbl_count && !found; j++) begin
        k = (idx + j) % tbl_count;
        if (tbl_known[k]) begin
          idx   = k;
          found = 1'b1;
        end
      end
      if (!found) begin
        if (tbl_count < DEPTH) idx = tbl_count;
        else op = OP_REMOVE;
      end
    end
    return table_op(op, idx, $urandom);
  endfunction

  // Send one item after a random gap; entered and left at a falling edge
  task automatic send_item(input in_item_t it);
    int gap;
    gap = in_quiet ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_item_i  <= it;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    table_replies_q.push_back(table_op_outcome(it));
    @(negedge clk_i);
  endtask

  task automatic test_empty_table();
    send_item(table_op(OP_READ, 0, 32'h0));
    send_item(table_op(OP_REMOVE, 0, 32'h0));
    send_item(table_op(OP_INSERT, 0, 32'h5555_5555));
  endtask

  task automatic test_extreme_words();
    send_item(table_op(OP_PLACE, 0, 32'h7FFF_FFFF));
    send_item(table_op(OP_PLACE, 1, 32'h8000_0000));
    send_item(table_op(OP_INSERT, 0, 32'hFFFF_FFFF));
    send_item(table_op(OP_INSERT, 2, 32'h0000_0000));
    send_item(table_op(OP_READ, 3, 32'hFFFF_FFFF));
    send_item(table_op(OP_READ, 0, 32'h0));
    send_item(table_op(OP_READ, 4, 32'h0));
    send_item(table_op(OP_REMOVE, 15, 32'h0));
  endtask

  // Place over a live entry, then place far beyond the count
  task automatic test_overwrite_and_gap();
    send_item(table_op(OP_PLACE, 0, 32'h1234_5678));
    send_item(table_op(OP_PLACE, 15, 32'hA5A5_5A5A));
    send_item(table_op(OP_READ, 15, 32'h0));
  endtask

  task automatic test_full_table();
    int unsigned k;
    while (tbl_count < DEPTH) begin
      k = 0;
      while (k < DEPTH - 1 && tbl_known[k]) k++;
      send_item(table_op(OP_PLACE, k, $urandom));
    end
    send_item(table_op(OP_INSERT, 0, 32'hDEAD_BEEF));
    send_item(table_op(OP_PLACE, 3, 32'hDEAD_BEEF));
  endtask

  task automatic test_random_ops();
    filling = 1'b0;
    for (int n = 0; n < 1750; n++) begin
      if (n % 64 == 0) begin
        in_quiet  = ($urandom_range(0, 4) == 0);
        out_quiet = ($urandom_range(0, 4) == 0);
      end
      send_item(pick_table_op());
      if (tbl_count == DEPTH && $urandom_range(0, 2) == 0) filling = 1'b0;
      else if (tbl_count == 0) filling = 1'b1;
    end
  endtask

  // Receiver back-pressure: after each taken result, stall for a drawn number of cycles
  always @(negedge clk_i) begin
    if (takes != takes_seen) begin
      takes_seen  = takes;
      hold_cycles = out_quiet ? 0 : $urandom_range(0, 17);
    end
    if (hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles = hold_cycles - 1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Compare each taken result with the oldest pending reply
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (table_replies_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d data %0d count %0d",
                   out_item_o.status, out_item_o.read_data, out_item_o.count);
      end else begin
        reply_due = table_replies_q.pop_front();
        if (out_item_o.status !== reply_due.status ||
            out_item_o.read_data !== reply_due.read_data ||
            out_item_o.count !== reply_due.count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: status %0d/%0d data %0d/%0d count %0d/%0d (exp/act)",
                     reply_due.status, out_item_o.status, reply_due.read_data,
                     out_item_o.read_data, reply_due.count, out_item_o.count);
        end
      end
      takes++;
    end
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    in_quiet    = 1'b0;
    out_quiet   = 1'b0;
    tbl_count   = 0;
    foreach (tbl_known[k]) begin
      tbl_known[k] = 1'b0;
      tbl_words[k] = '0;
    end
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_empty_table();
    test_extreme_words();
    test_overwrite_and_gap();
    test_full_table();
    test_random_ops();
    in_valid_i <= 1'b0;
    // drain, then allow for the longest shift of a full table
    while (table_replies_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (mismatches == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

  initial begin
    #1_500_000;
    $display("tb failed");
    $finish;
  end

endmodule
